// ===== sv/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants of the chained hash set: field widths,
// operation and status codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package chs_pkg;

   localparam int KEY_W    = 31;
   localparam int STATUS_W = 3;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_PRESENT   = 3'd2,
      ST_ABSENT    = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      logic clr_step;
      logic start_op;
      logic head_load;
      logic link_load;
      logic node_write;
      logic head_write;
      logic link_write;
      logic used_inc;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic hash_done;
      logic is_search;
      logic cur_zero;
      logic key_match;
      logic last_zero;
      logic pool_full;
   } dp_status_type;

endpackage

// ===== sv/chs_ram.sv =====
// ----------------------------------------------------------------------------
// chs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/chs_mod.sv =====
// ----------------------------------------------------------------------------
// chs_mod
// Bucket index unit: key modulo the bucket count. A mask for a power-of-two
// count, otherwise a multiply by a scaled reciprocal for the quotient and a
// multiply-back and subtract for the remainder, each step registered.
// ----------------------------------------------------------------------------
module chs_mod #(
   parameter int MODULUS = 1024
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic [chs_pkg::KEY_W-1:0]                     key,
   output logic [(MODULUS > 1 ? $clog2(MODULUS) : 1)-1:0] rem,
   output logic                                          done
);

   localparam int BW = (MODULUS > 1) ? $clog2(MODULUS) : 1;
   localparam int KW = chs_pkg::KEY_W;

   logic [BW-1:0] rem_ff;
   logic          done_ff;

   generate
      if ((MODULUS & (MODULUS - 1)) == 0) begin : g_mask
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else if (start) begin
               done_ff <= 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               rem_ff <= key[BW-1:0] & BW'(MODULUS - 1);
            end
         end
      end else begin : g_recip
         // quotient = (key * RECIP) >> SH, exact for every KW-bit key
         localparam int SH = KW + BW;
         localparam longint unsigned RECIP =
            ((64'd1 << SH) + 64'(MODULUS) - 64'd1) / 64'(MODULUS);

         logic [KW-1:0] key_ff;
         logic [KW-1:0] quo_ff;
         logic          quo_go_ff;
         logic          rem_go_ff;
         logic [63:0]   prod;

         assign prod = 64'(key_ff) * RECIP;

         always_ff @(posedge clock) begin
            if (reset) begin
               quo_go_ff <= 1'b0;
               rem_go_ff <= 1'b0;
               done_ff   <= 1'b0;
            end else begin
               quo_go_ff <= start;
               rem_go_ff <= quo_go_ff;
               if (start) begin
                  done_ff <= 1'b0;
               end else if (rem_go_ff) begin
                  done_ff <= 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               key_ff <= key;
            end
            if (quo_go_ff) begin
               quo_ff <= KW'(prod >> SH);
            end
            if (rem_go_ff) begin
               rem_ff <= BW'(key_ff - quo_ff * KW'(MODULUS));
            end
         end
      end
   endgenerate

   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

// ===== sv/chs_datapath.sv =====
// ----------------------------------------------------------------------------
// chs_datapath
// Request registers, chain pointers, node allocation counter, head clearing
// sweep, and the head, key and link memories.
// ----------------------------------------------------------------------------
module chs_datapath #(
   parameter int NUM_BUCKETS = 1024,
   parameter int POOL_NODES  = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  chs_pkg::cmd_type             cmd,
   input  logic                         req_func,
   input  logic [chs_pkg::KEY_W-1:0]    req_key,
   output chs_pkg::dp_status_type       sts
);

   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int NW = $clog2(POOL_NODES + 1);
   localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;

   logic                      func_ff;
   logic [chs_pkg::KEY_W-1:0] key_ff;
   logic [NW-1:0]             cur_ff;
   logic [NW-1:0]             last_ff;
   logic [NW-1:0]             used_ff;
   logic [BW-1:0]             clr_ff;

   logic [BW-1:0]             bucket;
   logic                      hash_done;
   logic [NW-1:0]             head_rdata;
   logic [NW-1:0]             link_rdata;
   logic [chs_pkg::KEY_W-1:0] key_rdata;
   logic [NW-1:0]             cur_m1;
   logic [NW-1:0]             last_m1;
   logic [NW-1:0]             used_p1;

   logic                      head_we;
   logic [BW-1:0]             head_waddr;
   logic [NW-1:0]             head_wdata;
   logic                      link_we;
   logic [IW-1:0]             link_waddr;
   logic [NW-1:0]             link_wdata;

   assign cur_m1  = cur_ff - NW'(1);
   assign last_m1 = last_ff - NW'(1);
   assign used_p1 = used_ff + NW'(1);

   chs_mod #(
      .MODULUS (NUM_BUCKETS)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (cmd.start_op),
      .key   (req_key),
      .rem   (bucket),
      .done  (hash_done)
   );

   assign head_we    = cmd.clr_step | cmd.head_write;
   assign head_waddr = cmd.clr_step ? clr_ff : bucket;
   assign head_wdata = cmd.clr_step ? '0 : used_p1;

   chs_ram #(
      .WIDTH (NW),
      .DEPTH (NUM_BUCKETS)
   ) u_heads (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (bucket),
      .rd_data (head_rdata)
   );

   chs_ram #(
      .WIDTH (chs_pkg::KEY_W),
      .DEPTH (POOL_NODES)
   ) u_keys (
      .clock   (clock),
      .wr_en   (cmd.node_write),
      .wr_addr (used_ff[IW-1:0]),
      .wr_data (key_ff),
      .rd_addr (cur_m1[IW-1:0]),
      .rd_data (key_rdata)
   );

   assign link_we    = cmd.node_write | cmd.link_write;
   assign link_waddr = cmd.node_write ? used_ff[IW-1:0] : last_m1[IW-1:0];
   assign link_wdata = cmd.node_write ? '0 : used_p1;

   chs_ram #(
      .WIDTH (NW),
      .DEPTH (POOL_NODES)
   ) u_links (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (cur_m1[IW-1:0]),
      .rd_data (link_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         used_ff <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + BW'(1);
         end
         if (cmd.used_inc) begin
            used_ff <= used_p1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_op) begin
         func_ff <= req_func;
         key_ff  <= req_key;
      end
      if (cmd.head_load) begin
         cur_ff  <= head_rdata;
         last_ff <= '0;
      end else if (cmd.link_load) begin
         cur_ff  <= link_rdata;
         last_ff <= cur_ff;
      end
   end

   assign sts.clr_done  = (clr_ff == BW'(NUM_BUCKETS - 1));
   assign sts.hash_done = hash_done;
   assign sts.is_search = (func_ff == chs_pkg::FUNC_SEARCH);
   assign sts.cur_zero  = (cur_ff == '0);
   assign sts.key_match = (key_rdata == key_ff);
   assign sts.last_zero = (last_ff == '0);
   assign sts.pool_full = (used_ff == NW'(POOL_NODES));

endmodule

// ===== sv/chs_ctrl.sv =====
// ----------------------------------------------------------------------------
// chs_ctrl
// Controller: head clearing after reset, hashing, chain walk, node append
// and the response strobe.
// ----------------------------------------------------------------------------
module chs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  chs_pkg::dp_status_type  sts,
   output chs_pkg::cmd_type        cmd,
   output logic                    rsp_valid,
   output chs_pkg::status_type     rsp_status
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_HEAD,
      S_WALK,
      S_NODE_CHK,
      S_WR_NODE,
      S_WR_LINK
   } state_type;

   state_type           state_ff;
   logic                rsp_valid_ff;
   chs_pkg::status_type rsp_status_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_CLEAR:    cmd.clr_step  = 1'b1;
         S_IDLE:     cmd.start_op  = start;
         S_HASH:     cmd           = '0;
         S_HEAD:     cmd.head_load = 1'b1;
         S_WALK:     cmd           = '0;
         S_NODE_CHK: cmd.link_load = ~sts.key_match;
         S_WR_NODE: begin
            cmd.node_write = 1'b1;
            cmd.head_write = sts.last_zero;
            cmd.used_inc   = sts.last_zero;
         end
         S_WR_LINK: begin
            cmd.link_write = 1'b1;
            cmd.used_inc   = 1'b1;
         end
         default:    cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= chs_pkg::ST_INSERTED;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               if (sts.clr_done) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_HASH;
               end
            end
            S_HASH: begin
               if (sts.hash_done) begin
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: state_ff <= S_WALK;
            S_WALK: begin
               if (!sts.cur_zero) begin
                  state_ff <= S_NODE_CHK;
               end else if (sts.is_search) begin
                  state_ff      <= S_IDLE;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= chs_pkg::ST_ABSENT;
               end else if (sts.pool_full) begin
                  state_ff      <= S_IDLE;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= chs_pkg::ST_FULL;
               end else begin
                  state_ff <= S_WR_NODE;
               end
            end
            S_NODE_CHK: begin
               if (sts.key_match) begin
                  state_ff      <= S_IDLE;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= sts.is_search ? chs_pkg::ST_PRESENT
                                                 : chs_pkg::ST_DUPLICATE;
               end else begin
                  state_ff <= S_WALK;
               end
            end
            S_WR_NODE: begin
               if (sts.last_zero) begin
                  state_ff      <= S_IDLE;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= chs_pkg::ST_INSERTED;
               end else begin
                  state_ff <= S_WR_LINK;
               end
            end
            S_WR_LINK: begin
               state_ff      <= S_IDLE;
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= chs_pkg::ST_INSERTED;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== sv/chained_hash_set.sv =====
// ----------------------------------------------------------------------------
// chained_hash_set
// Set of 31-bit keys in a hash table with separate chaining over a fixed
// node pool; each request is an insert or a search and gives one response.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one request is
// handled at a time. After reset busy stays high while the bucket head
// memory is swept clear. A request is handled in order by hashing (a mask
// when NUM_BUCKETS is a power of two, otherwise reciprocal multiply, then
// multiply back and subtract), the head read, and one memory read and one
// compare for every chain node compared. On a miss a new insert writes the
// node, and also the tail link when the bucket is not empty.
// The response strobe rsp_valid is high for exactly one cycle, the first
// idle cycle, and cannot be held off.
// ----------------------------------------------------------------------------
module chained_hash_set #(
   parameter int NUM_BUCKETS = 1024,
   parameter int POOL_NODES  = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic [chs_pkg::KEY_W-1:0]         req_key,
   output logic                              rsp_valid,
   output logic [chs_pkg::STATUS_W-1:0]      rsp_status
);

   chs_pkg::cmd_type       cmd;
   chs_pkg::dp_status_type sts;
   chs_pkg::status_type    status;

   chs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .sts        (sts),
      .cmd        (cmd),
      .rsp_valid  (rsp_valid),
      .rsp_status (status)
   );

   chs_datapath #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .POOL_NODES  (POOL_NODES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_func (req_func),
      .req_key  (req_key),
      .sts      (sts)
   );

   assign rsp_status = status;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("response strobe outside the end of a request");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == chs_pkg::ST_FULL) |-> sts.pool_full)
      else $error("pool full reported with free nodes");

   a_search_codes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == chs_pkg::ST_PRESENT ||
                     rsp_status == chs_pkg::ST_ABSENT)) |-> sts.is_search)
      else $error("search status for an insert request");

endmodule

// ===== sim/chs_status_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_status_checker
// Watches the request and response channels of the chained hash set, keeps
// its own bucket table and node pool, predicts the status of every accepted
// request and compares each response against the oldest prediction.
// ----------------------------------------------------------------------------
module chs_status_checker #(
   parameter int NUM_BUCKETS = 1024,
   parameter int POOL_NODES  = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic                         req_func,
   input  logic [chs_pkg::KEY_W-1:0]    req_key,
   input  logic                         rsp_valid,
   input  logic [chs_pkg::STATUS_W-1:0] rsp_status,
   output int                           fail_count,
   output int                           pending,
   output int                           checked,
   output int                           full_hits
);

   typedef struct {
      logic                      func;
      logic [chs_pkg::KEY_W-1:0] key;
      chs_pkg::status_type       status;
   } lookup_type;

   // links and heads hold node index + 1, zero = no node
   int unsigned               bucket_head [NUM_BUCKETS];
   logic [chs_pkg::KEY_W-1:0] node_key    [POOL_NODES];
   int unsigned               node_next   [POOL_NODES];
   int unsigned               nodes_taken;
   lookup_type                status_fifo [$];

   function automatic chs_pkg::status_type hash_set_lookup(
      logic func, logic [chs_pkg::KEY_W-1:0] key);
      int unsigned bucket;
      int unsigned cur;
      int unsigned last;
      int unsigned steps;
      bit          found;
      bucket = key % NUM_BUCKETS;
      cur    = bucket_head[bucket];
      last   = 0;
      steps  = 0;
      found  = 1'b0;
      while (cur != 0 && steps < POOL_NODES && !found) begin
         if (node_key[cur-1] == key) begin
            found = 1'b1;
         end else begin
            last = cur;
            cur  = node_next[cur-1];
            steps++;
         end
      end
      if (func == chs_pkg::FUNC_SEARCH) return found ? chs_pkg::ST_PRESENT
                                                     : chs_pkg::ST_ABSENT;
      if (found) return chs_pkg::ST_DUPLICATE;
      if (nodes_taken >= POOL_NODES) return chs_pkg::ST_FULL;
      node_key[nodes_taken]  = key;
      node_next[nodes_taken] = 0;
      if (last == 0) bucket_head[bucket] = nodes_taken + 1;
      else node_next[last-1] = nodes_taken + 1;
      nodes_taken++;
      return chs_pkg::ST_INSERTED;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      full_hits  = 0;
   end

   always @(posedge clock) begin
      lookup_type exp;
      if (reset) begin
         foreach (bucket_head[i]) bucket_head[i] = 0;
         nodes_taken = 0;
         status_fifo.delete();
         pending <= 0;
      end else begin
         if (rsp_valid) begin
            if (status_fifo.size() == 0) begin
               $display("%0t: response status %0d with no request outstanding",
                        $time, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               exp = status_fifo.pop_front();
               checked <= checked + 1;
               if (rsp_status !== exp.status) begin
                  $display("%0t: func %0d key %0d: expected status %0d, actual %0d",
                           $time, exp.func, exp.key, exp.status, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            exp.func   = req_func;
            exp.key    = req_key;
            exp.status = hash_set_lookup(req_func, req_key);
            if (exp.status == chs_pkg::ST_FULL) full_hits <= full_hits + 1;
            status_fifo.push_back(exp);
         end
         pending <= status_fifo.size();
      end
   end

endmodule

// ===== sim/chained_hash_set_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set_tb
// Drives insert and search requests into the chained hash set: a directed
// pass over empty buckets, chain tails and key extremes, then random traffic
// clustered on a few hot buckets until the node pool overflows. Responses
// are checked by chs_status_checker; random sender gaps, no gaps at the end.
// ----------------------------------------------------------------------------
module chained_hash_set_tb;

   localparam int NUM_REQUESTS = 1700;
   localparam int QUIET_TAIL   = 250;
   localparam int STALL_LIMIT  = 20000;
   localparam int HOT_COUNT    = 40;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         start      = 1'b0;
   logic                         req_func   = chs_pkg::FUNC_INSERT;
   logic [chs_pkg::KEY_W-1:0]    req_key    = '0;
   logic                         busy;
   logic                         rsp_valid;
   logic [chs_pkg::STATUS_W-1:0] rsp_status;

   int fail_count;
   int pending;
   int checked;
   int full_hits;
   int stall_cycles = 0;
   int inserts      = 0;
   int searches     = 0;
   bit idle_on      = 1'b0;

   logic [chs_pkg::KEY_W-1:0] inserted_keys [$];
   logic [9:0]                hot_bucket    [HOT_COUNT];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   chained_hash_set dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_func  (req_func),
      .req_key   (req_key),
      .rsp_valid (rsp_valid),
      .rsp_status(rsp_status)
   );

   chs_status_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_func  (req_func),
      .req_key   (req_key),
      .rsp_valid (rsp_valid),
      .rsp_status(rsp_status),
      .fail_count(fail_count),
      .pending   (pending),
      .checked   (checked),
      .full_hits (full_hits)
   );

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_request(input logic func, input logic [chs_pkg::KEY_W-1:0] key);
      req_func <= func;
      req_key  <= key;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (func == chs_pkg::FUNC_INSERT) begin
         inserts++;
         inserted_keys.push_back(key);
      end else begin
         searches++;
      end
      if (idle_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   function automatic logic [chs_pkg::KEY_W-1:0] hot_key();
      logic [20:0] upper;
      upper = 21'($urandom_range(0, 21'h1FFFFF));
      return {upper, hot_bucket[$urandom_range(0, HOT_COUNT-1)]};
   endfunction

   function automatic logic [chs_pkg::KEY_W-1:0] known_key();
      return inserted_keys[$urandom_range(0, inserted_keys.size()-1)];
   endfunction

   function automatic logic [chs_pkg::KEY_W-1:0] rand_key();
      return chs_pkg::KEY_W'($urandom);
   endfunction

   initial begin
      int pick;
      hot_bucket[0] = 10'd0;
      hot_bucket[1] = 10'd1023;
      for (int i = 2; i < HOT_COUNT; i++) hot_bucket[i] = 10'($urandom_range(0, 1023));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty buckets, chain tails, duplicates, key extremes
      idle_on = 1'b1;
      send_request(chs_pkg::FUNC_SEARCH, 31'd0);
      send_request(chs_pkg::FUNC_INSERT, 31'd0);
      send_request(chs_pkg::FUNC_INSERT, 31'd0);
      send_request(chs_pkg::FUNC_SEARCH, 31'd0);
      send_request(chs_pkg::FUNC_INSERT, 31'd1024);
      send_request(chs_pkg::FUNC_INSERT, 31'h7FFFFC00);
      send_request(chs_pkg::FUNC_SEARCH, 31'd2048);
      send_request(chs_pkg::FUNC_SEARCH, 31'h7FFFFC00);
      send_request(chs_pkg::FUNC_SEARCH, 31'd1024);
      send_request(chs_pkg::FUNC_INSERT, 31'd1024);
      send_request(chs_pkg::FUNC_SEARCH, 31'h7FFFFFFF);
      send_request(chs_pkg::FUNC_INSERT, 31'h7FFFFFFF);
      send_request(chs_pkg::FUNC_INSERT, 31'd1023);
      send_request(chs_pkg::FUNC_SEARCH, 31'd2047);
      send_request(chs_pkg::FUNC_SEARCH, 31'd1023);
      send_request(chs_pkg::FUNC_INSERT, 31'h55555555);
      send_request(chs_pkg::FUNC_INSERT, 31'h2AAAAAAA);
      send_request(chs_pkg::FUNC_SEARCH, 31'h2AAAAAAA);

      start <= 1'b0;
      do @(posedge clock); while (pending != 0);

      for (int n = 0; n < NUM_REQUESTS; n++) begin
         if (n % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
         if (n >= NUM_REQUESTS - QUIET_TAIL) idle_on = 1'b0;
         if (n == NUM_REQUESTS / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
         pick = $urandom_range(0, 99);
         if (inserts < 1150) begin
            // filling the pool
            if (pick < 55) send_request(chs_pkg::FUNC_INSERT, hot_key());
            else if (pick < 65) send_request(chs_pkg::FUNC_INSERT, rand_key());
            else if (pick < 75) send_request(chs_pkg::FUNC_INSERT, known_key());
            else if (pick < 90) send_request(chs_pkg::FUNC_SEARCH, known_key());
            else send_request(chs_pkg::FUNC_SEARCH, rand_key());
         end else begin
            if (pick < 20) send_request(chs_pkg::FUNC_INSERT, hot_key());
            else if (pick < 30) send_request(chs_pkg::FUNC_INSERT, rand_key());
            else if (pick < 50) send_request(chs_pkg::FUNC_INSERT, known_key());
            else if (pick < 80) send_request(chs_pkg::FUNC_SEARCH, known_key());
            else if (pick < 90) send_request(chs_pkg::FUNC_SEARCH, hot_key());
            else send_request(chs_pkg::FUNC_SEARCH, rand_key());
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (64) @(posedge clock);

      $display("Covered %0d requests: %0d inserts, %0d searches, %0d responses checked.",
               inserts + searches, inserts, searches, checked);
      $display("Pool overflow rejected %0d inserts; hot buckets built long chains.",
               full_hits);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
